/* src/lip_pkg.sv */
// Shared types and constants for the label influence propagation block.
// No dependencies.
package lip_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam int unsigned DistBits = 18;
  localparam int unsigned VecBits  = 10;

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_INIT  = 9'b000000010,
    ST_POP   = 9'b000000100,
    ST_CRD   = 9'b000001000,
    ST_NADR  = 9'b000010000,
    ST_NRD   = 9'b000100000,
    ST_NUPD  = 9'b001000000,
    ST_RDWT  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  // Neighbor offsets in the order NW, N, NE, E, SE, S, SW, W.
  function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
    case (k)
      3'd0: nb_dx = -2'sd1;
      3'd1: nb_dx = 2'sd0;
      3'd2: nb_dx = 2'sd1;
      3'd3: nb_dx = 2'sd1;
      3'd4: nb_dx = 2'sd1;
      3'd5: nb_dx = 2'sd0;
      3'd6: nb_dx = -2'sd1;
      default: nb_dx = -2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
    case (k)
      3'd0: nb_dy = -2'sd1;
      3'd1: nb_dy = -2'sd1;
      3'd2: nb_dy = -2'sd1;
      3'd3: nb_dy = 2'sd0;
      3'd4: nb_dy = 2'sd1;
      3'd5: nb_dy = 2'sd1;
      3'd6: nb_dy = 2'sd1;
      default: nb_dy = 2'sd0;
    endcase
  endfunction

endpackage

/* src/lip_queue.sv */
// Work queue: a circular FIFO of pixel indexes held in one synchronous memory.
// Depends on nothing but its parameters.
module lip_queue #(
  parameter int unsigned Depth = 131072,
  parameter int unsigned IdxBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               push_i,
  input  logic [IdxBits-1:0] push_data_i,
  input  logic               pop_i,
  output logic [IdxBits-1:0] pop_data_o,
  output logic               empty_o,
  output logic               full_o
);
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [IdxBits-1:0] mem [Depth];
  logic [AddrBits-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  function automatic logic [AddrBits-1:0] inc(input logic [AddrBits-1:0] a);
    if ({{(32-AddrBits){1'b0}}, a} == Depth - 1) inc = '0;
    else inc = a + 1'b1;
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntBits'(Depth));

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (clear_i) begin
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else begin
      if (push_i && !full_o) tail_d = inc(tail_q);
      if (pop_i && !empty_o) head_d = inc(head_q);
      if ((push_i && !full_o) && !(pop_i && !empty_o)) cnt_d = cnt_q + 1'b1;
      else if (!(push_i && !full_o) && (pop_i && !empty_o)) cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o && !clear_i) mem[tail_q] <= push_data_i;
    pop_data_o <= mem[head_q];
  end

endmodule

/* src/lip_store.sv */
// Cell store: one synchronous memory with a single read and a single write port.
// The write port updates either the whole word or only its seed part.
// Depends on nothing but its parameters.
module lip_store #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrBits = 16,
  parameter int unsigned DataBits = 54,
  parameter int unsigned SeedBits = 17
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic                seed_we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataBits-1:0] rdata_o
);
  logic [DataBits-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    else if (seed_we_i) begin
      mem[waddr_i][DataBits-1 -: SeedBits] <= wdata_i[DataBits-1 -: SeedBits];
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/label_influence_propagation.sv */
// Top level of the label influence propagation block.
// Uses lip_pkg, lip_store and lip_queue.
//
// Usage: configuration writes set image_width (index 0) and image_height
// (index 1) while the block is idle. Input beats carry an action: load stores
// the next pixel's seed label and mask in raster order, start runs the
// breadth-first propagation, read returns the next pixel's result.
// A load gives no output beat and leaves the block idle for the next item. A
// read waits until the output register is free, registers its beat there and
// returns to idle; a load may be taken while an earlier beat still waits.
// Start first sweeps all width*height cells, reading and then rewriting each,
// to seed the queue, then finds each popped cell's coordinates by counting down
// the rows above it and visits its eight neighbors: one inside the image passes
// the address, read and update states on the cell store's single read port, one
// outside it only the address state. Its length depends on the data; it ends with one status beat.
// Reset clears the positions, the queue and the overflow flag and sets both
// dimensions to 256; the cell store keeps no reset value and must be loaded.
// While the receiver stalls, the output beat holds; a read or start that
// finishes meanwhile waits behind it and no new item is taken.
module label_influence_propagation
  import lip_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned LABEL_BITS = 16,
  parameter int unsigned QUEUE_DEPTH = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] pixel_label_i,
  input  logic        mask_bit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [15:0] out_label_o,
  output logic        reached_o,
  output logic [17:0] dist_sq_o,
  output logic signed [9:0] offset_x_o,
  output logic signed [9:0] offset_y_o,
  output logic        last_o
);
  localparam int unsigned XBits = $clog2(MAX_WIDTH);
  localparam int unsigned YBits = $clog2(MAX_HEIGHT);
  localparam int unsigned IdxBits = XBits + YBits;
  localparam int unsigned NCells = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CBits = $clog2(NCells + 1);
  localparam int unsigned WBits = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HBits = $clog2(MAX_HEIGHT + 1);
  // Cell word: seed label, seed mask, result label, dist, vx, vy, open.
  localparam int unsigned DataBits = 2 * LABEL_BITS + 1 + DistBits + 2 * VecBits + 1;

  typedef struct packed {
    logic [LABEL_BITS-1:0] seed;
    logic                  mask;
    logic [LABEL_BITS-1:0] lab;
    logic [DistBits-1:0]   dsq;
    logic signed [VecBits-1:0] vx;
    logic signed [VecBits-1:0] vy;
    logic                  open;
  } cell_t;

  state_e state_q, state_d;
  logic [8:0] width_q, height_q;
  logic [WBits-1:0] w_eff;
  logic [HBits-1:0] h_eff;
  logic [CBits-1:0] n_cells;
  logic [CBits-1:0] load_pos_q, read_pos_q, sweep_q;
  logic [XBits-1:0] cx_q;
  logic [YBits-1:0] cy_q;
  logic [2:0] k_q;
  logic ovf_q;
  cell_t cur_q;
  logic [IdxBits-1:0] tgt_q;
  logic signed [VecBits-1:0] nvx_q, nvy_q;
  logic [DistBits-1:0] nd_q;
  logic nvalid_q;

  logic out_valid_q;
  logic status_q, reached_q, last_q, rd_last_q;
  logic [15:0] lab_out_q;
  logic [17:0] dist_out_q;
  logic signed [9:0] vx_out_q, vy_out_q;
  logic out_free;

  // Memory ports.
  logic we, seed_we;
  logic [IdxBits-1:0] waddr, raddr;
  cell_t wdata, rdata;
  logic [DataBits-1:0] rdata_raw;
  logic q_clear, q_push, q_pop, q_empty, q_full;
  logic [IdxBits-1:0] q_pdata, q_rdata;

  always_comb begin
    if (width_q == '0) w_eff = WBits'(1);
    else if ({23'b0, width_q} > MAX_WIDTH) w_eff = WBits'(MAX_WIDTH);
    else w_eff = WBits'(width_q);
    if (height_q == '0) h_eff = HBits'(1);
    else if ({23'b0, height_q} > MAX_HEIGHT) h_eff = HBits'(MAX_HEIGHT);
    else h_eff = HBits'(height_q);
  end

  logic [WBits+HBits-1:0] n_prod;
  assign n_prod  = w_eff * h_eff;
  assign n_cells = CBits'(n_prod);

  function automatic logic [IdxBits-1:0] cidx(input logic [YBits-1:0] y,
                                              input logic [XBits-1:0] x,
                                              input logic [WBits-1:0] w);
    logic [YBits+WBits-1:0] p;
    p = y * w;
    cidx = IdxBits'(p) + IdxBits'(x);
  endfunction

  lip_store #(
    .Depth(NCells), .AddrBits(IdxBits), .DataBits(DataBits), .SeedBits(LABEL_BITS + 1)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .seed_we_i(seed_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_i  (raddr),
    .rdata_o  (rdata_raw)
  );
  assign rdata = cell_t'(rdata_raw);

  lip_queue #(.Depth(QUEUE_DEPTH), .IdxBits(IdxBits)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (q_clear),
    .push_i     (q_push),
    .push_data_i(q_pdata),
    .pop_i      (q_pop),
    .pop_data_o (q_rdata),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  logic in_acc;
  assign cfg_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  // The output register can take a new beat when empty or when its beat leaves.
  assign out_free    = !out_valid_q || !out_stall_i;

  // Positions as indexes, wrapped to 0 past the image.
  logic [CBits-1:0] lp, rp;
  assign lp = (load_pos_q >= n_cells) ? '0 : load_pos_q;
  assign rp = (read_pos_q >= n_cells) ? '0 : read_pos_q;

  // Neighbor coordinates.
  logic signed [XBits+1:0] nx;
  logic signed [YBits+1:0] ny;
  logic n_in;
  assign nx = $signed({2'b00, cx_q}) + (XBits+2)'(nb_dx(k_q));
  assign ny = $signed({2'b00, cy_q}) + (YBits+2)'(nb_dy(k_q));
  assign n_in = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, w_eff}))
                && (ny < $signed({1'b0, h_eff}));

  logic signed [VecBits-1:0] vx_c, vy_c;
  logic [2*VecBits-1:0] vx2, vy2;
  assign vx_c = cur_q.vx - VecBits'(nb_dx(k_q));
  assign vy_c = cur_q.vy - VecBits'(nb_dy(k_q));
  assign vx2 = vx_c * vx_c;
  assign vy2 = vy_c * vy_c;

  logic take;
  assign take = rdata.open || (rdata.lab != '0 && nd_q < rdata.dsq);

  // Pixel index of the seed sweep, taken from its counter.
  logic [IdxBits-1:0] sweep_idx;
  assign sweep_idx = IdxBits'(sweep_q);

  // Popped index to (x, y): counted down by row to avoid a divider.
  logic [IdxBits-1:0] rem_q;

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    seed_we = 1'b0;
    waddr   = '0;
    wdata   = rdata;
    raddr   = '0;
    q_clear = 1'b0;
    q_push  = 1'b0;
    q_pop   = 1'b0;
    q_pdata = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_i)
            ACT_LOAD: begin
              // Only the seed part is written; the last results stay readable.
              seed_we = 1'b1;
              waddr = IdxBits'(lp);
              wdata = '0;
              wdata.seed = LABEL_BITS'(pixel_label_i);
              wdata.mask = mask_bit_i;
            end
            ACT_START: begin
              q_clear = 1'b1;
              state_d = ST_INIT;
            end
            ACT_READ: begin
              state_d = ST_RDWT;
            end
            default: ;
          endcase
        end
        raddr = IdxBits'(rp);
      end
      ST_INIT: begin
        // Two-phase sweep: even = read, odd = rewrite and seed the queue.
        raddr = sweep_idx;
        if (nvalid_q) begin
          we = 1'b1;
          waddr = tgt_q;
          wdata.lab = rdata.seed;
          wdata.dsq = '0;
          wdata.vx = '0;
          wdata.vy = '0;
          wdata.open = (rdata.seed == '0) && rdata.mask;
          if (rdata.seed != '0) begin
            q_push = 1'b1;
            q_pdata = tgt_q;
          end
          if (sweep_q >= n_cells) state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (q_empty) state_d = ST_OUT;
        else begin
          q_pop = 1'b1;
          state_d = ST_CRD;
        end
      end
      ST_CRD: begin
        // The popped index is held in tgt_q so the cell stays on the read port.
        raddr = nvalid_q ? tgt_q : q_rdata;
        if (rem_q < IdxBits'(w_eff) && nvalid_q) state_d = ST_NADR;
      end
      ST_NADR: begin
        raddr = tgt_q;
        if (k_q == 3'd0 && !nvalid_q) state_d = ST_NADR;
        if (nvalid_q) begin
          if (n_in) state_d = ST_NRD;
          else if (k_q == 3'd7) state_d = ST_POP;
        end
      end
      ST_NRD: begin
        raddr = tgt_q;
        state_d = ST_NUPD;
      end
      ST_NUPD: begin
        if (take) begin
          we = 1'b1;
          waddr = tgt_q;
          wdata.open = 1'b0;
          wdata.lab = cur_q.lab;
          wdata.dsq = nd_q;
          wdata.vx = nvx_q;
          wdata.vy = nvy_q;
          q_push = 1'b1;
          q_pdata = tgt_q;
        end
        state_d = (k_q == 3'd7) ? ST_POP : ST_NADR;
      end
      ST_RDWT: begin
        raddr = tgt_q;
        if (out_free) state_d = ST_IDLE;
      end
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= 9'd256;
      height_q    <= 9'd256;
      load_pos_q  <= '0;
      read_pos_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      nvalid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
      if ((state_q == ST_RDWT || state_q == ST_OUT) && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          nvalid_q <= 1'b0;
          if (in_acc) begin
            case (action_i)
              ACT_LOAD: load_pos_q <= (lp + 1'b1 >= n_cells) ? '0 : lp + 1'b1;
              ACT_START: begin
                ovf_q <= 1'b0;
                load_pos_q <= '0;
                read_pos_q <= '0;
              end
              ACT_READ: begin
                read_pos_q <= (rp + 1'b1 >= n_cells) ? '0 : rp + 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_INIT: begin
          if (q_push && q_full) ovf_q <= 1'b1;
          nvalid_q <= !nvalid_q;
        end
        ST_POP: nvalid_q <= 1'b0;
        ST_CRD: begin
          if (!nvalid_q) nvalid_q <= 1'b1;
          else if (rem_q < IdxBits'(w_eff)) nvalid_q <= 1'b0;
        end
        ST_NADR: begin
          if (!nvalid_q) nvalid_q <= 1'b1;
          else if (!n_in) begin
            nvalid_q <= 1'b0;
          end
        end
        ST_NUPD: begin
          if (q_push && q_full) ovf_q <= 1'b1;
          nvalid_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && action_i == ACT_START) begin
          sweep_q <= '0;
        end
        if (in_acc && action_i == ACT_READ) begin
          tgt_q <= IdxBits'(rp);
        end
        rd_last_q <= (rp + 1'b1 >= n_cells);
      end
      ST_INIT: begin
        if (!nvalid_q) begin
          tgt_q <= sweep_idx;
          sweep_q <= sweep_q + 1'b1;
        end
      end
      ST_POP: begin
        rem_q <= '0;
        cy_q <= '0;
      end
      ST_CRD: begin
        if (!nvalid_q) begin
          rem_q <= q_rdata;
          tgt_q <= q_rdata;
          k_q <= 3'd0;
        end else begin
          cur_q <= rdata;
          if (rem_q >= IdxBits'(w_eff)) begin
            rem_q <= rem_q - IdxBits'(w_eff);
            cy_q <= cy_q + 1'b1;
          end else begin
            cx_q <= XBits'(rem_q);
          end
        end
      end
      ST_NADR: begin
        if (nvalid_q && !n_in) k_q <= k_q + 1'b1;
        tgt_q <= cidx(YBits'(ny), XBits'(nx), w_eff);
        nvx_q <= vx_c;
        nvy_q <= vy_c;
        nd_q  <= DistBits'(vx2) + DistBits'(vy2);
      end
      ST_NUPD: k_q <= k_q + 1'b1;
      ST_RDWT: begin
        if (out_free) begin
          status_q   <= 1'b0;
          lab_out_q  <= 16'(rdata.lab);
          reached_q  <= (rdata.lab != '0);
          dist_out_q <= (rdata.lab != '0) ? 18'(rdata.dsq) : '0;
          vx_out_q   <= (rdata.lab != '0) ? 10'(rdata.vx) : '0;
          vy_out_q   <= (rdata.lab != '0) ? 10'(rdata.vy) : '0;
          last_q     <= rd_last_q;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          status_q   <= ovf_q;
          lab_out_q  <= '0;
          reached_q  <= 1'b0;
          dist_out_q <= '0;
          vx_out_q   <= '0;
          vy_out_q   <= '0;
          last_q     <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_label_o = lab_out_q;
  assign reached_o   = reached_q;
  assign dist_sq_o   = dist_out_q;
  assign offset_x_o  = vx_out_q;
  assign offset_y_o  = vy_out_q;
  assign last_o      = last_q;

endmodule

/* tb/tb_label_influence_propagation.sv */
// Self-checking testbench for label_influence_propagation.
// Depends on lip_pkg and the block itself; pixel results are checked against an
// in-bench flood-fill predictor, and a handful of directed rows are checked against typed values.
`timescale 1ns / 1ps

module tb_label_influence_propagation;
  import lip_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int CellMax = 65536;
  localparam int QueueCap = 131072;
  localparam int CycleLimit = 10000000;
  localparam int LongHold = 400;

  typedef struct {
    logic        status;
    logic [15:0] label;
    logic        reached;
    logic [17:0] dsq;
    logic [9:0]  ox;
    logic [9:0]  oy;
    logic        last;
  } pix_result_t;

  typedef struct {
    logic [1:0]  act;
    logic [15:0] label;
    logic        mask;
    bit          typed;
    pix_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_WIDTH;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_LOAD;
  logic [15:0] pixel_label = '0;
  logic        mask_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [15:0] out_label;
  logic        reached;
  logic [17:0] dist_sq;
  logic signed [9:0] offset_x;
  logic signed [9:0] offset_y;
  logic        last;

  label_influence_propagation u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .pixel_label_i(pixel_label), .mask_bit_i(mask_bit),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .out_label_o(out_label), .reached_o(reached),
    .dist_sq_o(dist_sq), .offset_x_o(offset_x), .offset_y_o(offset_y),
    .last_o(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  int unsigned img_w, img_h;
  logic [15:0] seed_lbl [CellMax];
  bit          seed_msk [CellMax];
  logic [15:0] map_lbl  [CellMax];
  int          map_dist [CellMax];
  int          map_vx   [CellMax];
  int          map_vy   [CellMax];
  bit          map_open [CellMax];
  int          load_pos, read_pos;
  bit          spill;
  const int    step_dx [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
  const int    step_dy [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};

  pix_result_t pending_px[$];
  int          errors = 0;
  int          cycles = 0;
  int          items = 0;
  bit          no_idle = 1'b0;
  int          hold_ask = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  function automatic int clamp_dim(int unsigned v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : v;
  endfunction

  function automatic void enqueue(ref int q[$], input int idx);
    if (q.size() >= QueueCap) spill = 1'b1;
    else q.push_back(idx);
  endfunction

  // Breadth-first label spread from all seeds, neighbors in NW..W order.
  function automatic void flood();
    int w, n, c, cx, cy, nx, ny, t, ax, ay, d;
    int q[$];
    w = clamp_dim(img_w);
    n = w * clamp_dim(img_h);
    spill = 1'b0;
    for (int i = 0; i < n; i++) begin
      map_lbl[i] = seed_lbl[i];
      map_dist[i] = 0;
      map_vx[i] = 0;
      map_vy[i] = 0;
      map_open[i] = (seed_lbl[i] == 0) && seed_msk[i];
      if (seed_lbl[i] != 0) enqueue(q, i);
    end
    while (q.size() != 0) begin
      c = q.pop_front();
      cx = c % w;
      cy = c / w;
      for (int k = 0; k < 8; k++) begin
        nx = cx + step_dx[k];
        ny = cy + step_dy[k];
        if (nx < 0 || ny < 0 || nx >= w || ny >= n / w) continue;
        t = ny * w + nx;
        ax = map_vx[c] - step_dx[k];
        ay = map_vy[c] - step_dy[k];
        d = ax * ax + ay * ay;
        if (map_open[t] || (map_lbl[t] != 0 && d < map_dist[t])) begin
          map_open[t] = 1'b0;
          map_lbl[t] = map_lbl[c];
          map_dist[t] = d;
          map_vx[t] = ax;
          map_vy[t] = ay;
          enqueue(q, t);
        end
      end
    end
  endfunction

  function automatic bit predict(input logic [1:0] a, input logic [15:0] l, input logic m,
                                 output pix_result_t r);
    int n, p;
    bit hit;
    n = clamp_dim(img_w) * clamp_dim(img_h);
    r = '{default: '0};
    case (a)
      ACT_LOAD: begin
        p = (load_pos >= n) ? 0 : load_pos;
        seed_lbl[p] = l;
        seed_msk[p] = m;
        load_pos = (p + 1 >= n) ? 0 : p + 1;
        return 1'b0;
      end
      ACT_START: begin
        flood();
        load_pos = 0;
        read_pos = 0;
        r.status = spill;
        return 1'b1;
      end
      ACT_READ: begin
        p = (read_pos >= n) ? 0 : read_pos;
        hit = map_lbl[p] != 0;
        r.label = map_lbl[p];
        r.reached = hit;
        r.dsq = hit ? map_dist[p][17:0] : '0;
        r.ox = hit ? map_vx[p][9:0] : '0;
        r.oy = hit ? map_vy[p][9:0] : '0;
        r.last = (p + 1 >= n);
        read_pos = (p + 1 >= n) ? 0 : p + 1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string fld, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, fld, got, want);
    errors++;
  endtask

  // Output checker.
  always @(posedge clk) begin
    pix_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        e = pending_px.pop_front();
        if (status !== e.status) report("status", status, e.status);
        if (out_label !== e.label) report("out_label", out_label, e.label);
        if (reached !== e.reached) report("reached", reached, e.reached);
        if (dist_sq !== e.dsq) report("dist_sq", dist_sq, e.dsq);
        if (offset_x !== e.ox) report("offset_x", offset_x, e.ox);
        if (offset_y !== e.oy) report("offset_y", offset_y, e.oy);
        if (last !== e.last) report("last", last, e.last);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    int r;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_done) begin
      hold_done <= hold_ask;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      out_stall <= (r >= 60);
      if (r >= 96) stall_left <= $urandom_range(5, 30);
      else if (r >= 60) stall_left <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'h0000;
    if (r < 80) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  // Offers one beat and waits for it to be taken. Returns at the accepting edge
  // with valid still high, so the next call may follow without a gap.
  task automatic send(input logic [1:0] a, input logic [15:0] l, input logic m,
                      input bit typed, input pix_result_t tr);
    int gap;
    pix_result_t r;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    pixel_label <= l;
    mask_bit <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict(a, l, m, r)) pending_px.push_back(typed ? tr : r);
    if (a != ACT_IGNORED) items++;
  endtask

  task automatic send_rand(input logic [1:0] a);
    send(a, pick_label(), $urandom_range(0, 9) < 7, 1'b0, '{default: '0});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    img_w = w[8:0];
    img_h = h[8:0];
  endtask

  // One image: full load, start, then a mix of reads, reloads, restarts and noise.
  task automatic run_image(input int unsigned w, input int unsigned h, input bit hold);
    int n, ops, r;
    configure(w, h);
    n = clamp_dim(img_w) * clamp_dim(img_h);
    no_idle = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) send_rand(ACT_IGNORED);
      send_rand(ACT_LOAD);
    end
    send_rand(ACT_START);
    if (hold) hold_ask++;
    ops = n / 2 + 1 + $urandom_range(0, n / 2);
    for (int i = 0; i < ops; i++) begin
      r = $urandom_range(0, 99);
      if (r < 72) send_rand(ACT_READ);
      else if (r < 86) send_rand(ACT_LOAD);
      else if (r < 94) send_rand(ACT_START);
      else send_rand(ACT_IGNORED);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    stim_row_t rows[$];
    pix_result_t zero_res, seed_res;
    img_w = 256;
    img_h = 256;
    load_pos = 0;
    read_pos = 0;
    spill = 1'b0;
    zero_res = '{default: '0};
    seed_res = '{default: '0};
    seed_res.label = 16'hFFFF;
    seed_res.reached = 1'b1;

    // 3x2 image: a full-range seed, a small seed, one barrier cell.
    rows.push_back('{ACT_LOAD, 16'hFFFF, 1'b1, 1'b0, zero_res});
    rows.push_back('{ACT_LOAD, 16'h0000, 1'b1, 1'b0, zero_res});
    rows.push_back('{ACT_LOAD, 16'h0000, 1'b0, 1'b0, zero_res});
    rows.push_back('{ACT_IGNORED, 16'hFFFF, 1'b1, 1'b0, zero_res});
    rows.push_back('{ACT_LOAD, 16'h0000, 1'b1, 1'b0, zero_res});
    rows.push_back('{ACT_LOAD, 16'h0001, 1'b0, 1'b0, zero_res});
    rows.push_back('{ACT_LOAD, 16'h0000, 1'b1, 1'b0, zero_res});
    rows.push_back('{ACT_START, 16'h0000, 1'b0, 1'b1, zero_res});
    rows.push_back('{ACT_READ, 16'h0000, 1'b0, 1'b1, seed_res});
    rows.push_back('{ACT_READ, 16'h0000, 1'b0, 1'b0, zero_res});
    rows.push_back('{ACT_READ, 16'h0000, 1'b0, 1'b1, zero_res});
    rows.push_back('{ACT_READ, 16'h0000, 1'b0, 1'b0, zero_res});
    rows.push_back('{ACT_READ, 16'h0000, 1'b0, 1'b0, zero_res});
    rows.push_back('{ACT_READ, 16'h0000, 1'b0, 1'b0, zero_res});
    rows.push_back('{ACT_READ, 16'h0000, 1'b0, 1'b1, seed_res});
    rows.push_back('{ACT_START, 16'h0000, 1'b0, 1'b1, zero_res});
    rows.push_back('{ACT_READ, 16'hFFFF, 1'b1, 1'b1, seed_res});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(3, 2);
    foreach (rows[i]) send(rows[i].act, rows[i].label, rows[i].mask, rows[i].typed, rows[i].res);

    // Register extremes: zero, the 9-bit maximum, and a height past the limit.
    run_image(0, 0, 1'b0);
    run_image(511, 1, 1'b1);
    run_image(1, 300, 1'b0);
    run_image(0, 7, 1'b0);
    while (items < 1000)
      run_image($urandom_range(1, 9), $urandom_range(1, 9), 1'b0);

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* label_influence_propagation.f */
src/lip_pkg.sv
src/lip_queue.sv
src/lip_store.sv
src/label_influence_propagation.sv
tb/tb_label_influence_propagation.sv
